// ===== rtl/core/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg
// Types and constants shared by the run-length byte encoder modules.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int unsigned BYTE_W = 8;

    // Shortest run that is sent as a count followed by a value.
    localparam logic [BYTE_W-1:0] MIN_COUNT = BYTE_W'(2);

    // One queue entry: up to two closed runs caused by one input request.
    // Run A is the run closed by a differing byte or a full count.
    // Run B is the block's closing run and carries the final result.
    typedef struct packed {
        logic              a_vld;
        logic [BYTE_W-1:0] a_byte;
        logic [BYTE_W-1:0] a_len;
        logic              b_vld;
        logic [BYTE_W-1:0] b_byte;
        logic [BYTE_W-1:0] b_len;
    } t_run_rec;

    // Result slots of one queue entry, in the order they are sent.
    typedef enum logic [1:0] {
        POS_A_CNT,
        POS_A_VAL,
        POS_B_CNT,
        POS_B_VAL
    } t_pos;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/run_length_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// Byte-stream run-length encoder with a count/value tagged result stream.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one byte per request and a
// flag on the block's final byte. Output channel (o_out_valid / i_out_ready)
// carries one result per request: a run count (o_is_count high) followed by
// its byte for runs of two or more, or the byte alone for a single byte.
// o_final_result marks the last result of each block. Runs are closed at
// MAX_RUN bytes and a new run starts with the next equal byte.
// The run that an accepted request closes is written to the entry queue, and
// its results then pass through the registered output stage.
// Throughput: one input byte per cycle while the entry queue has room; the
// output stage sends one result per cycle while i_out_ready is high, so the
// sustained input rate is one byte per cycle over the average results per byte.
// Reset clears the open run, the queue and the output stage. When the
// receiver stalls, the output holds and the queue of QUEUE_DEPTH entries
// fills; o_in_ready then falls until an entry is drained.
// ----------------------------------------------------------------------------
module run_length_byte_encoder #(
    parameter int unsigned MAX_RUN     = 255,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rle_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_block_end,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rle_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_is_count,
    output logic                       o_final_result
);
    import rle_pkg::*;

    t_run_rec push_rec;
    t_run_rec head_rec;
    t_q_stat  q_stat;
    logic     push;
    logic     pop;

    rle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_block_end (i_block_end),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    rle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_stat  (q_stat)
    );

    rle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (head_rec),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_count     (o_is_count),
        .o_final_result (o_final_result)
    );

`ifndef SYNTHESIS
    // The block's last result is always a value byte.
    a_final_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_final_result |-> !o_is_count)
        else $error("final result tagged as a count");

    // A count always lies between two and the longest run.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_count |->
            (o_out_byte >= MIN_COUNT) && (o_out_byte <= BYTE_W'(MAX_RUN)))
        else $error("run count out of range");

    // A delivered count is followed at once by its value byte.
    a_count_then_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_is_count |=> o_out_valid && !o_is_count)
        else $error("count not followed by its value");
`endif

endmodule

// ===== rtl/core/rle_front.sv =====
// ----------------------------------------------------------------------------
// rle_front
// Accepts input bytes, tracks the open run and writes closed runs to the queue.
// ----------------------------------------------------------------------------
module rle_front #(
    parameter int unsigned MAX_RUN = 255
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [rle_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                      i_block_end,
    input  rle_pkg::t_q_stat          i_q_stat,
    output logic                      o_push,
    output rle_pkg::t_run_rec         o_rec
);
    import rle_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_RUN);

    logic [BYTE_W-1:0] r_run_byte;
    logic [BYTE_W-1:0] r_run_len;
    logic [BYTE_W-1:0] n_run_byte;
    logic [BYTE_W-1:0] n_run_len;
    logic [BYTE_W-1:0] new_len;
    logic              accept;
    logic              extend;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // A byte joins the open run unless it differs or the run is already full.
    assign extend  = (r_run_len != '0) && (i_data_byte == r_run_byte) && (r_run_len < MAX_LEN);
    assign new_len = extend ? r_run_len + BYTE_W'(1) : BYTE_W'(1);

    always_comb begin
        o_rec.a_vld  = !extend && (r_run_len != '0);
        o_rec.a_byte = r_run_byte;
        o_rec.a_len  = r_run_len;
        o_rec.b_vld  = i_block_end;
        o_rec.b_byte = i_data_byte;
        o_rec.b_len  = new_len;
        if (i_block_end) begin
            n_run_byte = '0;
            n_run_len  = '0;
        end else begin
            n_run_byte = i_data_byte;
            n_run_len  = new_len;
        end
    end

    assign o_push = accept && (o_rec.a_vld || o_rec.b_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_byte <= '0;
            r_run_len  <= '0;
        end else if (accept) begin
            r_run_byte <= n_run_byte;
            r_run_len  <= n_run_len;
        end
    end

endmodule

// ===== rtl/core/rle_fifo.sv =====
// ----------------------------------------------------------------------------
// rle_fifo
// Short register queue of closed-run entries between the front and back parts.
// ----------------------------------------------------------------------------
module rle_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rle_pkg::t_run_rec i_rec,
    input  logic              i_pop,
    output rle_pkg::t_run_rec o_rec,
    output rle_pkg::t_q_stat  o_stat
);
    import rle_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_run_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rle_back.sv =====
// ----------------------------------------------------------------------------
// rle_back
// Expands the queue head into count and value results, one per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module rle_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rle_pkg::t_run_rec          i_rec,
    input  rle_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rle_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_is_count,
    output logic                       o_final_result
);
    import rle_pkg::*;

    t_pos              r_pos;
    t_pos              n_pos;
    t_pos              sel;
    logic              has_a_cnt;
    logic              has_b_cnt;
    logic              has_after;
    logic              emit;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_count;

    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_is_count;
    logic              r_final;

    assign has_a_cnt = i_rec.a_vld && (i_rec.a_len >= MIN_COUNT);
    assign has_b_cnt = i_rec.b_vld && (i_rec.b_len >= MIN_COUNT);

    // The output stage takes a new result when it is empty or being drained.
    assign emit = !i_q_stat.empty && (!r_out_vld || i_ready);

    // Output block: pick the first present slot at or after r_pos.
    always_comb begin
        priority if (r_pos == POS_A_CNT && has_a_cnt) begin
            sel = POS_A_CNT;
        end else if ((r_pos == POS_A_CNT || r_pos == POS_A_VAL) && i_rec.a_vld) begin
            sel = POS_A_VAL;
        end else if (r_pos != POS_B_VAL && has_b_cnt) begin
            sel = POS_B_CNT;
        end else begin
            sel = POS_B_VAL;
        end

        unique case (sel)
            POS_A_CNT: has_after = 1'b1;
            POS_A_VAL: has_after = i_rec.b_vld;
            POS_B_CNT: has_after = 1'b1;
            POS_B_VAL: has_after = 1'b0;
            default:   has_after = 1'b0;
        endcase

        unique case (sel)
            POS_A_CNT: begin
                sel_byte  = i_rec.a_len;
                sel_count = 1'b1;
            end
            POS_A_VAL: begin
                sel_byte  = i_rec.a_byte;
                sel_count = 1'b0;
            end
            POS_B_CNT: begin
                sel_byte  = i_rec.b_len;
                sel_count = 1'b1;
            end
            default: begin
                sel_byte  = i_rec.b_byte;
                sel_count = 1'b0;
            end
        endcase

        o_pop = emit && !has_after;
    end

    // Next-state block.
    always_comb begin
        n_pos = r_pos;
        if (emit) begin
            if (!has_after) begin
                n_pos = POS_A_CNT;
            end else begin
                unique case (sel)
                    POS_A_CNT: n_pos = POS_A_VAL;
                    POS_A_VAL: n_pos = POS_B_CNT;
                    POS_B_CNT: n_pos = POS_B_VAL;
                    default:   n_pos = POS_A_CNT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_A_CNT;
            r_out_vld <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= sel_byte;
            r_is_count <= sel_count;
            r_final    <= (sel == POS_B_VAL);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_out_byte     = r_out_byte;
    assign o_is_count     = r_is_count;
    assign o_final_result = r_final;

endmodule
